FILE: src/sft_pkg.sv
`default_nettype none

package sft_pkg;

	// result slots produced by one input word at most
	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int SLOT_W  = $clog2(MAX_RES);

	// length of the "content-length" key
	localparam logic [3:0] KEY_LEN = 4'd14;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// token kinds
	localparam logic [2:0] KIND_CMD   = 3'd0;
	localparam logic [2:0] KIND_NAME  = 3'd1;
	localparam logic [2:0] KIND_VALUE = 3'd2;
	localparam logic [2:0] KIND_BODY  = 3'd3;
	localparam logic [2:0] KIND_SUM   = 3'd4;

	// frame status codes
	localparam logic [2:0] FS_OK        = 3'd0;
	localparam logic [2:0] FS_HEARTBEAT = 3'd1;
	localparam logic [2:0] FS_SHORT     = 3'd2;
	localparam logic [2:0] FS_TRAILING  = 3'd3;
	localparam logic [2:0] FS_UNTERM    = 3'd4;

	typedef enum logic [5:0] {
		PH_SKIP  = 6'b000001,
		PH_CMD   = 6'b000010,
		PH_NAME  = 6'b000100,
		PH_VALUE = 6'b001000,
		PH_BODY  = 6'b010000,
		PH_TRAIL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [2:0]  token_kind;
		logic        token_end;
		logic [2:0]  frame_status;
		logic [31:0] body_length;
		logic        last_result;
	} result_t;

	typedef struct packed {
		result_t [MAX_RES-1:0] slot;
		logic [CNT_W-1:0]      count;
	} res_list_t;

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic result_t byte_word(input logic [2:0] kind, input logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.token_kind = kind;
		return r;
	endfunction

	function automatic result_t end_word(input logic [2:0] kind);
		result_t r;
		r = '0;
		r.token_kind = kind;
		r.token_end  = 1'b1;
		return r;
	endfunction

	function automatic result_t sum_word(input logic [2:0] status, input logic [31:0] blen);
		result_t r;
		r = '0;
		r.token_kind   = KIND_SUM;
		r.frame_status = status;
		r.body_length  = blen;
		return r;
	endfunction

	function automatic res_list_t list_push(input res_list_t l, input result_t e);
		res_list_t r;
		r = l;
		if (l.count < CNT_W'(MAX_RES)) begin
			r.slot[l.count[SLOT_W-1:0]] = e;
			r.count = l.count + CNT_W'(1);
		end
		return r;
	endfunction

	// close a token: mark the last word if it is an open byte of the same kind,
	// otherwise add an empty end word
	function automatic res_list_t list_end(input res_list_t l, input logic [2:0] kind);
		res_list_t        r;
		logic [CNT_W-1:0] li;
		result_t          p;
		r  = l;
		li = l.count - CNT_W'(1);
		p  = l.slot[li[SLOT_W-1:0]];
		if (l.count != '0 && p.byte_valid && p.token_kind == kind && !p.token_end) begin
			r.slot[li[SLOT_W-1:0]].token_end = 1'b1;
		end else begin
			r = list_push(l, end_word(kind));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/stomp_frame_tokenizer.sv
`default_nettype none

// An accepted word passes the input register, then the result buffer.
// Throughput: one input word per cycle while each yields at most one result
// and the output is not held; a word yielding more (up to 4) holds the single
// output port till its last leaves; the next word waits in the input register.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser
// to its idle state; the parser state also returns there after every frame.
module stomp_frame_tokenizer #(
	parameter int LENGTH_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  sft_pkg::item_t     item,
	input  wire                item_valid,
	output logic               item_stall,
	output sft_pkg::result_t   result,
	output logic               result_valid,
	input  wire                result_stall
);

	localparam int CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

	// Parser state carried from word to word.
	typedef struct packed {
		sft_pkg::phase_t        ph;        // parse phase
		logic                   esc;       // backslash seen, next byte literal
		logic                   hv;        // a CR is held back
		logic [7:0]             hb;        // the held byte
		logic                   tok_empty; // no byte emitted since last token end
		logic [3:0]             m_idx;     // chars of the key matched so far
		logic                   m_miss;    // header name is not the key
		logic                   vil;       // value still being parsed as a length
		logic                   len_seen;  // content-length header found
		logic [LENGTH_BITS-1:0] len;       // parsed content-length
		logic [31:0]            body_cnt;  // body bytes emitted, saturating
		logic                   trail;     // non-newline after the body
	} state_t;

	// State plus the list of result words built for one input word.
	typedef struct packed {
		state_t             st;
		sft_pkg::res_list_t rl;
	} work_t;

	localparam state_t ST_RESET = '{
		ph:        sft_pkg::PH_SKIP,
		esc:       1'b0,
		hv:        1'b0,
		hb:        8'd0,
		tok_empty: 1'b1,
		m_idx:     4'd0,
		m_miss:    1'b0,
		vil:       1'b0,
		len_seen:  1'b0,
		len:       '0,
		body_cnt:  32'd0,
		trail:     1'b0
	};

	// ------------------------------------------------------------------
	// Token helpers. Each models one action of the parser on the state and
	// the result list; the whole word is a short chain of these.
	// ------------------------------------------------------------------

	// Emit one token byte: update the key matcher, the length parser or the
	// body count depending on the kind, then append the byte.
	function automatic work_t emit(input work_t w, input logic [2:0] kind,
			input logic [7:0] b);
		work_t                  r;
		logic [LENGTH_BITS+3:0] wide;
		r = w;
		// len * 10 + digit; the digit is the low nibble of an ASCII numeral
		wide = ({4'd0, w.st.len} << 3) + ({4'd0, w.st.len} << 1)
			+ {{LENGTH_BITS{1'b0}}, b[3:0]};
		if (kind == sft_pkg::KIND_NAME) begin
			if (!w.st.m_miss && w.st.m_idx < sft_pkg::KEY_LEN
					&& b == sft_pkg::key_char(w.st.m_idx)) begin
				r.st.m_idx = w.st.m_idx + 4'd1;
			end else begin
				r.st.m_miss = 1'b1;
			end
		end else if (kind == sft_pkg::KIND_VALUE && w.st.vil) begin
			if (b inside {[sft_pkg::CH_ZERO:sft_pkg::CH_NINE]}) begin
				r.st.len = (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
					? '1 : wide[LENGTH_BITS-1:0];
			end else begin
				r.st.vil = 1'b0;
			end
		end else if (kind == sft_pkg::KIND_BODY) begin
			if (w.st.body_cnt != '1) begin
				r.st.body_cnt = w.st.body_cnt + 32'd1;
			end
		end
		r.st.tok_empty = 1'b0;
		r.rl = sft_pkg::list_push(w.rl, sft_pkg::byte_word(kind, b));
		return r;
	endfunction

	// Release a held CR as an ordinary byte.
	function automatic work_t flush(input work_t w, input logic [2:0] kind);
		work_t r;
		r = w;
		if (w.st.hv) begin
			r.st.hv = 1'b0;
			r = emit(r, kind, w.st.hb);
		end
		return r;
	endfunction

	// A literal byte: a CR is held back in case an LF follows.
	function automatic work_t put_lit(input work_t w, input logic [2:0] kind,
			input logic [7:0] b);
		work_t r;
		r = flush(w, kind);
		if (b == sft_pkg::CH_CR) begin
			r.st.hb = b;
			r.st.hv = 1'b1;
		end else begin
			r = emit(r, kind, b);
		end
		return r;
	endfunction

	function automatic work_t end_tok(input work_t w, input logic [2:0] kind);
		work_t r;
		r = w;
		r.rl = sft_pkg::list_end(w.rl, kind);
		r.st.tok_empty = 1'b1;
		return r;
	endfunction

	// Header name closed: only the first exact key match arms the length parser.
	function automatic work_t name_done(input work_t w);
		work_t r;
		r = w;
		if (!w.st.m_miss && w.st.m_idx == sft_pkg::KEY_LEN && !w.st.len_seen) begin
			r.st.len_seen = 1'b1;
			r.st.len      = '0;
			r.st.vil      = 1'b1;
		end
		r.st.m_idx  = 4'd0;
		r.st.m_miss = 1'b0;
		return r;
	endfunction

	function automatic logic [2:0] phase_kind(input sft_pkg::phase_t ph);
		logic [2:0] k;
		case (ph)
			sft_pkg::PH_NAME:  k = sft_pkg::KIND_NAME;
			sft_pkg::PH_VALUE: k = sft_pkg::KIND_VALUE;
			default:           k = sft_pkg::KIND_CMD;
		endcase
		return k;
	endfunction

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	sft_pkg::item_t                          item_s1;   // input register
	logic                                    valid_s1;
	state_t                                  st_q;      // parser state
	sft_pkg::result_t [sft_pkg::MAX_RES-1:0] res_q;     // result buffer
	logic [sft_pkg::CNT_W-1:0]               rem_q;     // words left to send
	logic [sft_pkg::SLOT_W-1:0]              rd_q;      // next word to send

	work_t nxt;
	logic  take;
	logic  buf_free;
	logic  adv;
	logic  in_take;

	// ------------------------------------------------------------------
	// One word's parse: input register -> result buffer
	// ------------------------------------------------------------------
	always_comb begin
		work_t            w;
		logic [7:0]       b;
		logic             last;
		logic             run_line;
		logic [2:0]       k;
		logic [2:0]       status;
		logic [sft_pkg::CNT_W-1:0] li;

		w        = '0;
		w.st     = st_q;
		b        = item_s1.data_byte;
		last     = item_s1.last_byte;
		run_line = 1'b0;
		k        = sft_pkg::KIND_CMD;
		status   = sft_pkg::FS_OK;

		// the NUL that closes the frame is not data
		if (!(last && b == sft_pkg::CH_NUL)) begin
			case (w.st.ph)
				sft_pkg::PH_SKIP: begin
					if (!(b inside {sft_pkg::CH_CR, sft_pkg::CH_LF})) begin
						w.st.ph  = sft_pkg::PH_CMD;
						run_line = 1'b1;
					end
				end
				sft_pkg::PH_CMD, sft_pkg::PH_NAME, sft_pkg::PH_VALUE: begin
					run_line = 1'b1;
				end
				sft_pkg::PH_BODY: begin
					w = emit(w, sft_pkg::KIND_BODY, b);
					if (w.st.len_seen && CMP_W'(w.st.body_cnt) >= CMP_W'(w.st.len)) begin
						w = end_tok(w, sft_pkg::KIND_BODY);
						w.st.ph = sft_pkg::PH_TRAIL;
					end
				end
				sft_pkg::PH_TRAIL: begin
					if (!(b inside {sft_pkg::CH_CR, sft_pkg::CH_LF})) begin
						w.st.trail = 1'b1;
					end
				end
				default: begin
					w.st.ph = sft_pkg::PH_SKIP;
				end
			endcase
		end

		// command and header lines
		if (run_line) begin
			k = phase_kind(w.st.ph);
			if (w.st.esc) begin
				w.st.esc = 1'b0;
				w = put_lit(w, k, b);
			end else if (b == sft_pkg::CH_BSL) begin
				w = flush(w, k);
				w.st.esc = 1'b1;
			end else if (b == sft_pkg::CH_LF) begin
				// a held CR before the line end is trimmed
				w.st.hv = 1'b0;
				case (w.st.ph)
					sft_pkg::PH_CMD: begin
						w = end_tok(w, sft_pkg::KIND_CMD);
						w.st.ph = sft_pkg::PH_NAME;
					end
					sft_pkg::PH_NAME: begin
						if (w.st.tok_empty) begin
							// blank line: headers done, body starts (a zero length ends it at once)
							if (w.st.len_seen && w.st.len == '0) begin
								w = end_tok(w, sft_pkg::KIND_BODY);
								w.st.ph = sft_pkg::PH_TRAIL;
							end else begin
								w.st.ph = sft_pkg::PH_BODY;
							end
						end else begin
							// name with no colon: empty value
							w = name_done(w);
							w.st.vil = 1'b0;
							w = end_tok(w, sft_pkg::KIND_NAME);
							w = end_tok(w, sft_pkg::KIND_VALUE);
						end
					end
					default: begin
						w = end_tok(w, sft_pkg::KIND_VALUE);
						w.st.vil = 1'b0;
						w.st.ph  = sft_pkg::PH_NAME;
					end
				endcase
			end else if (b == sft_pkg::CH_COLON && w.st.ph == sft_pkg::PH_NAME) begin
				w = flush(w, sft_pkg::KIND_NAME);
				w = name_done(w);
				w = end_tok(w, sft_pkg::KIND_NAME);
				w.st.ph = sft_pkg::PH_VALUE;
			end else begin
				w = put_lit(w, k, b);
			end
		end

		// frame end: close what is open, then the summary word
		if (last) begin
			case (w.st.ph)
				sft_pkg::PH_CMD: begin
					w = flush(w, sft_pkg::KIND_CMD);
					w = end_tok(w, sft_pkg::KIND_CMD);
					status = sft_pkg::FS_UNTERM;
				end
				sft_pkg::PH_NAME: begin
					if (w.st.hv || !w.st.tok_empty) begin
						w = flush(w, sft_pkg::KIND_NAME);
						w = name_done(w);
						w = end_tok(w, sft_pkg::KIND_NAME);
						w = end_tok(w, sft_pkg::KIND_VALUE);
					end
					status = sft_pkg::FS_UNTERM;
				end
				sft_pkg::PH_VALUE: begin
					w = flush(w, sft_pkg::KIND_VALUE);
					w = end_tok(w, sft_pkg::KIND_VALUE);
					status = sft_pkg::FS_UNTERM;
				end
				sft_pkg::PH_BODY: begin
					w = end_tok(w, sft_pkg::KIND_BODY);
					status = w.st.len_seen ? sft_pkg::FS_SHORT : sft_pkg::FS_OK;
				end
				sft_pkg::PH_TRAIL: begin
					status = w.st.trail ? sft_pkg::FS_TRAILING : sft_pkg::FS_OK;
				end
				default: begin
					status = sft_pkg::FS_HEARTBEAT;
				end
			endcase
			w.rl = sft_pkg::list_push(w.rl, sft_pkg::sum_word(status, w.st.body_cnt));
			w.st = ST_RESET;
		end

		// flag the final word of this input word
		li = w.rl.count - sft_pkg::CNT_W'(1);
		if (w.rl.count != '0) begin
			w.rl.slot[li[sft_pkg::SLOT_W-1:0]].last_result = 1'b1;
		end

		nxt = w;
	end

	// ------------------------------------------------------------------
	// Handshake. The buffer takes a new list once its last word leaves.
	// ------------------------------------------------------------------
	assign result_valid = (rem_q != '0);
	assign result       = res_q[rd_q];
	assign take         = result_valid && !result_stall;
	assign buf_free     = (rem_q == '0) || (rem_q == sft_pkg::CNT_W'(1) && take);
	assign adv          = valid_s1 && buf_free;
	assign item_stall   = valid_s1 && !buf_free;
	assign in_take      = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= ST_RESET;
			rem_q    <= '0;
			rd_q     <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				st_q  <= nxt.st;
				rem_q <= nxt.rl.count;
				rd_q  <= '0;
			end else if (take) begin
				rem_q <= rem_q - sft_pkg::CNT_W'(1);
				rd_q  <= rd_q + sft_pkg::SLOT_W'(1);
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item;
		end
		if (adv) begin
			res_q <= nxt.rl.slot;
		end
	end

endmodule

`default_nettype wire
